/* src/vna_pkg.sv */
package vna_pkg;

	// Field widths of the request and response beats
	localparam int OP_W     = 2;
	localparam int VIDX_W   = 12;
	localparam int POS_W    = 24;
	localparam int CORNER_W = 32;
	localparam int CNT_W    = 13;
	localparam int SUM_W    = 64;
	localparam int NRM_W    = 16;

	// Normalization datapath widths
	localparam int MAG_W    = 30;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int LEN_W    = 32;
	localparam int QUO_W    = 17;
	localparam int NUM_W    = MAG_W + 16;
	localparam int REM_W    = LEN_W + 1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_TRI   = 2'd1,
		OP_QUERY = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [NRM_W-1:0] nrm_t;

	localparam nrm_t NRM_ONE = 16'sd32767;

endpackage

/* src/vna_ifs.sv */
interface vna_req_if;
	import vna_pkg::*;
	logic                        valid;
	logic                        ready;
	logic [OP_W-1:0]             opcode;
	logic [VIDX_W-1:0]           vertex_index;
	pos_t                        pos_x;
	pos_t                        pos_y;
	pos_t                        pos_z;
	logic signed [CORNER_W-1:0]  corner_a;
	logic signed [CORNER_W-1:0]  corner_b;
	logic signed [CORNER_W-1:0]  corner_c;
	modport source (output valid, opcode, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, opcode, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

interface vna_rsp_if;
	import vna_pkg::*;
	logic              valid;
	logic              ready;
	logic [VIDX_W-1:0] queried_vertex;
	nrm_t              normal_x;
	nrm_t              normal_y;
	nrm_t              normal_z;
	logic              degenerate;
	modport source (output valid, queried_vertex, normal_x, normal_y, normal_z,
		degenerate, input ready);
	modport sink (input valid, queried_vertex, normal_x, normal_y, normal_z,
		degenerate, output ready);
endinterface

interface vna_cfg_if;
	import vna_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* src/vna_ram.sv */
module vna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/vertex_normal_accumulator_unit.sv */
// Area-weighted vertex normal accumulator. Load beats store a Q8.16 position and
// clear that vertex's 64-bit accumulators; triangle beats add the edge cross
// product into the accumulators of all three corners with saturation; query
// beats return the normal scaled to Q1.15 ((0,0,+1) and degenerate for a zero
// sum or an out-of-range vertex). Positions and sums live in two
// single-port-write memories with one read port each, so each item is handled
// alone: a load is written as it is taken, a triangle runs three position
// reads, a three-stage cross product and three read-modify-write passes on the
// sum memory, and a query runs a one-bit-per-cycle shift, a 32-step square
// root and a 17-step divider, all skipped when the sum is zero or the vertex is
// out of range. A query also waits while the previous response beat is still held.
// After reset the sum memory is swept to zero; no request beat is taken during
// the sweep, while configuration writes are taken at any time.
module vertex_normal_accumulator_unit #(
	parameter int MAX_VERTICES = 4096
) (
	input logic       clk,
	input logic       arst_n,
	vna_req_if.sink   req,
	vna_rsp_if.source rsp,
	vna_cfg_if.sink   cfg
);
	import vna_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);
	localparam logic [31:0] LIM_MAX = 32'(MAX_VERTICES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);
	localparam int VW = 3 * POS_W;
	localparam int SW = 3 * SUM_W;
	localparam int EW = POS_W + 1;
	localparam int PW = 2 * EW;
	localparam int CW = PW + 1;
	localparam logic [SUM_W-1:0] SQRT_TOP = 64'h4000_0000_0000_0000;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, T_RD, T_LAST, T_EDGE, T_MUL, T_CROSS, T_SRD, T_SWR,
		Q_RD, Q_CAP, Q_SHIFT, Q_SQ, Q_SUMSQ, Q_SQRT, Q_DINIT, Q_DIV, Q_OUT
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           clr_q;
	logic [CNT_W-1:0]        vc_q;
	logic [1:0]              cidx_q;
	logic [4:0]              step_q;
	logic [AW-1:0]           cor_q [3];
	logic [VW-1:0]           vtx_q [3];
	logic signed [EW-1:0]    e1_q [3];
	logic signed [EW-1:0]    e2_q [3];
	logic signed [PW-1:0]    prod_q [6];
	logic signed [CW-1:0]    cross_q [3];
	logic [VIDX_W-1:0]       qvi_q;
	logic                    bad_q;
	logic                    deg_q;
	logic                    neg_q [3];
	logic [SUM_W-1:0]        mag_q [3];
	logic [SQ_W-1:0]         sq_q [3];
	logic [SUM_W-1:0]        rad_q;
	logic [SUM_W-1:0]        root_q;
	logic [SUM_W-1:0]        bit_q;
	logic [LEN_W-1:0]        len_q;
	logic [REM_W-1:0]        rem_q [3];
	logic [QUO_W-1:0]        nlo_q [3];
	logic [QUO_W-1:0]        quo_q [3];
	logic                    ov_q;
	logic [VIDX_W-1:0]       ovi_q;
	nrm_t                    onx_q;
	nrm_t                    ony_q;
	nrm_t                    onz_q;
	logic                    odeg_q;

	logic                    acc;
	logic [31:0]             vi32;
	logic [AW-1:0]           vi_addr;
	logic                    vi_ok;
	logic [31:0]             vc32;
	logic [31:0]             lim;
	logic                    tri_ok;

	logic                    pos_we;
	logic [VW-1:0]           pos_wdata;
	logic [AW-1:0]           pos_raddr;
	logic [VW-1:0]           pos_rdata;
	logic                    sum_we;
	logic [AW-1:0]           sum_waddr;
	logic [SW-1:0]           sum_wdata;
	logic [AW-1:0]           sum_raddr;
	logic [SW-1:0]           sum_rdata;
	logic [SW-1:0]           sat_sum;

	logic signed [EW-1:0]    e1 [3];
	logic signed [EW-1:0]    e2 [3];
	logic [SUM_W-1:0]        sq_try;
	logic [LEN_W-1:0]        len_use;
	logic [NUM_W-1:0]        num [3];
	logic [REM_W-1:0]        rem_try [3];
	nrm_t                    nclamp [3];

	// Request decode and range checks
	assign acc       = req.valid && req.ready;
	assign vi32      = 32'(req.vertex_index);
	assign vi_addr   = vi32[AW-1:0];
	assign vi_ok     = vi32 < LIM_MAX;
	assign vc32      = 32'(vc_q);
	assign lim       = (vc32 < LIM_MAX) ? vc32 : LIM_MAX;
	assign tri_ok    = !req.corner_a[CORNER_W-1] && !req.corner_b[CORNER_W-1] &&
		!req.corner_c[CORNER_W-1] && (32'(req.corner_a) < lim) &&
		(32'(req.corner_b) < lim) && (32'(req.corner_c) < lim);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid          = ov_q;
	assign rsp.queried_vertex = ovi_q;
	assign rsp.normal_x       = onx_q;
	assign rsp.normal_y       = ony_q;
	assign rsp.normal_z       = onz_q;
	assign rsp.degenerate     = odeg_q;

	// Position memory: written by loads, read for triangle corners
	assign pos_we    = acc && (req.opcode == OP_LOAD) && vi_ok;
	assign pos_wdata = {req.pos_z, req.pos_y, req.pos_x};
	assign pos_raddr = cor_q[cidx_q];

	vna_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (vi_addr),
		.wdata (pos_wdata),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	// Saturating add of the cross product into the read sums
	always_comb begin
		logic [SUM_W:0] s;
		for (int k = 0; k < 3; k++) begin
			s = {sum_rdata[k*SUM_W+SUM_W-1], sum_rdata[k*SUM_W +: SUM_W]} +
				(SUM_W+1)'(cross_q[k]);
			if (s[SUM_W] != s[SUM_W-1]) begin
				sat_sum[k*SUM_W +: SUM_W] = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} :
					{1'b0, {(SUM_W-1){1'b1}}};
			end else begin
				sat_sum[k*SUM_W +: SUM_W] = s[SUM_W-1:0];
			end
		end
	end

	// Sum memory write: clearing sweep, load clear, or accumulate
	always_comb begin
		sum_we    = 1'b0;
		sum_waddr = cor_q[cidx_q];
		sum_wdata = '0;
		if (state_q == S_CLEAR) begin
			sum_we    = 1'b1;
			sum_waddr = clr_q;
		end else if (pos_we) begin
			sum_we    = 1'b1;
			sum_waddr = vi_addr;
		end else if (state_q == T_SWR) begin
			sum_we    = 1'b1;
			sum_wdata = sat_sum;
		end
	end
	assign sum_raddr = cor_q[cidx_q];

	vna_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	// Edge vectors from the three captured corners
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			e1[k] = EW'(pos_t'(vtx_q[1][k*POS_W +: POS_W])) -
				EW'(pos_t'(vtx_q[0][k*POS_W +: POS_W]));
			e2[k] = EW'(pos_t'(vtx_q[2][k*POS_W +: POS_W])) -
				EW'(pos_t'(vtx_q[0][k*POS_W +: POS_W]));
		end
	end

	// Square root trial, divider operands and output clamping
	assign sq_try  = root_q + bit_q;
	assign len_use = (root_q[LEN_W-1:0] == '0) ? LEN_W'(1) : root_q[LEN_W-1:0];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num[k]     = {mag_q[k][MAG_W-1:0], 15'd0} + NUM_W'(len_use >> 1);
			rem_try[k] = {rem_q[k][REM_W-2:0], nlo_q[k][QUO_W-1]};
			if (neg_q[k]) begin
				nclamp[k] = nrm_t'(QUO_W'(0) - ((quo_q[k] > QUO_W'(32768)) ?
					QUO_W'(32768) : quo_q[k]));
			end else begin
				nclamp[k] = (quo_q[k] > QUO_W'(32767)) ? NRM_ONE : nrm_t'(quo_q[k]);
			end
		end
	end

	// Sequencer, datapath registers and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			vc_q    <= '0;
			cidx_q  <= '0;
			step_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				vc_q <= cfg.data;
			end
			// drop a taken beat; the output step reloads the register itself
			if (ov_q && rsp.ready && state_q != Q_OUT) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						cidx_q <= '0;
						if (req.opcode == OP_TRI && tri_ok) begin
							cor_q[0] <= req.corner_a[AW-1:0];
							cor_q[1] <= req.corner_b[AW-1:0];
							cor_q[2] <= req.corner_c[AW-1:0];
							state_q  <= T_RD;
						end else if (req.opcode == OP_QUERY) begin
							cor_q[0] <= vi_addr;
							qvi_q    <= req.vertex_index;
							bad_q    <= !vi_ok;
							state_q  <= Q_RD;
						end
					end
				end
				T_RD: begin
					// issue corner reads, capture the previous one
					if (cidx_q != 2'd0) begin
						vtx_q[cidx_q - 2'd1] <= pos_rdata;
					end
					if (cidx_q == 2'd2) begin
						state_q <= T_LAST;
					end else begin
						cidx_q <= cidx_q + 2'd1;
					end
				end
				T_LAST: begin
					vtx_q[2] <= pos_rdata;
					state_q  <= T_EDGE;
				end
				T_EDGE: begin
					e1_q    <= e1;
					e2_q    <= e2;
					state_q <= T_MUL;
				end
				T_MUL: begin
					prod_q[0] <= e1_q[1] * e2_q[2];
					prod_q[1] <= e1_q[2] * e2_q[1];
					prod_q[2] <= e1_q[2] * e2_q[0];
					prod_q[3] <= e1_q[0] * e2_q[2];
					prod_q[4] <= e1_q[0] * e2_q[1];
					prod_q[5] <= e1_q[1] * e2_q[0];
					state_q   <= T_CROSS;
				end
				T_CROSS: begin
					cross_q[0] <= CW'(prod_q[0]) - CW'(prod_q[1]);
					cross_q[1] <= CW'(prod_q[2]) - CW'(prod_q[3]);
					cross_q[2] <= CW'(prod_q[4]) - CW'(prod_q[5]);
					cidx_q     <= '0;
					state_q    <= T_SRD;
				end
				T_SRD: begin
					state_q <= T_SWR;
				end
				T_SWR: begin
					// write back, then the next corner reads the updated entry
					if (cidx_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						cidx_q  <= cidx_q + 2'd1;
						state_q <= T_SRD;
					end
				end
				Q_RD: begin
					state_q <= Q_CAP;
				end
				Q_CAP: begin
					for (int k = 0; k < 3; k++) begin
						neg_q[k] <= sum_rdata[k*SUM_W+SUM_W-1];
						mag_q[k] <= sum_rdata[k*SUM_W+SUM_W-1] ?
							SUM_W'(0) - sum_rdata[k*SUM_W +: SUM_W] :
							sum_rdata[k*SUM_W +: SUM_W];
					end
					deg_q   <= bad_q || (sum_rdata == '0);
					state_q <= (bad_q || (sum_rdata == '0)) ? Q_OUT : Q_SHIFT;
				end
				Q_SHIFT: begin
					// shift all three until the largest fits in 30 bits
					if ((mag_q[0][SUM_W-1:MAG_W] != '0) || (mag_q[1][SUM_W-1:MAG_W] != '0) ||
							(mag_q[2][SUM_W-1:MAG_W] != '0)) begin
						for (int k = 0; k < 3; k++) begin
							mag_q[k] <= mag_q[k] >> 1;
						end
					end else begin
						state_q <= Q_SQ;
					end
				end
				Q_SQ: begin
					for (int k = 0; k < 3; k++) begin
						sq_q[k] <= mag_q[k][MAG_W-1:0] * mag_q[k][MAG_W-1:0];
					end
					state_q <= Q_SUMSQ;
				end
				Q_SUMSQ: begin
					rad_q   <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
					root_q  <= '0;
					bit_q   <= SQRT_TOP;
					state_q <= Q_SQRT;
				end
				Q_SQRT: begin
					// one result bit per cycle
					if (rad_q >= sq_try) begin
						rad_q  <= rad_q - sq_try;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q == SUM_W'(1)) begin
						state_q <= Q_DINIT;
					end
				end
				Q_DINIT: begin
					len_q <= len_use;
					for (int k = 0; k < 3; k++) begin
						rem_q[k] <= REM_W'(num[k][NUM_W-1:QUO_W]);
						nlo_q[k] <= num[k][QUO_W-1:0];
						quo_q[k] <= '0;
					end
					step_q  <= '0;
					state_q <= Q_DIV;
				end
				Q_DIV: begin
					// restoring division, one quotient bit per cycle
					for (int k = 0; k < 3; k++) begin
						if (rem_try[k] >= REM_W'(len_q)) begin
							rem_q[k] <= rem_try[k] - REM_W'(len_q);
							quo_q[k] <= {quo_q[k][QUO_W-2:0], 1'b1};
						end else begin
							rem_q[k] <= rem_try[k];
							quo_q[k] <= {quo_q[k][QUO_W-2:0], 1'b0};
						end
						nlo_q[k] <= nlo_q[k] << 1;
					end
					step_q <= step_q + 5'd1;
					if (step_q == 5'(QUO_W - 1)) begin
						state_q <= Q_OUT;
					end
				end
				Q_OUT: begin
					// hold until the response register is free
					if (!ov_q || rsp.ready) begin
						ov_q   <= 1'b1;
						ovi_q  <= qvi_q;
						odeg_q <= deg_q;
						onx_q  <= deg_q ? nrm_t'(0) : nclamp[0];
						ony_q  <= deg_q ? nrm_t'(0) : nclamp[1];
						onz_q  <= deg_q ? NRM_ONE : nclamp[2];
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_rsp_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q) == Q_OUT)
		else $error("response raised outside the query output step");

	a_deg_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && odeg_q |-> onx_q == nrm_t'(0) && ony_q == nrm_t'(0) && onz_q == NRM_ONE)
		else $error("degenerate response without the fallback normal");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == Q_DIV |-> rem_q[0] < REM_W'(len_q) && rem_q[1] < REM_W'(len_q) &&
			rem_q[2] < REM_W'(len_q))
		else $error("divider remainder not below the length");

	a_shift_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == Q_SQ |-> mag_q[0][SUM_W-1:MAG_W] == '0 &&
			mag_q[1][SUM_W-1:MAG_W] == '0 && mag_q[2][SUM_W-1:MAG_W] == '0)
		else $error("magnitudes not reduced before squaring");

endmodule

/* sim/normal_checker.sv */
module normal_checker
	import vna_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	vna_req_if        req,
	vna_rsp_if        rsp,
	vna_cfg_if        cfg,
	output int        errors,
	output int        pending
);

	localparam int VERTS = 4096;

	typedef struct {
		logic [VIDX_W-1:0] vtx;
		nrm_t              nx;
		nrm_t              ny;
		nrm_t              nz;
		logic              deg;
	} normal_rec_t;

	// Shadow copy of the block's state
	longint      vpos_x [VERTS];
	longint      vpos_y [VERTS];
	longint      vpos_z [VERTS];
	longint      acc_x [VERTS];
	longint      acc_y [VERTS];
	longint      acc_z [VERTS];
	longint      vcount;
	normal_rec_t normals_due[$];
	normal_rec_t want;
	normal_rec_t got;
	longint      ca, cb, cc, lim;
	longint      e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
	int          mism;

	function automatic longint sat_sum(longint a, longint b);
		longint r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63])
			r = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
		return r;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic nrm_t scale_part(longint unsigned mag, bit neg, longint unsigned len);
		longint unsigned q;
		q = (mag * 32768 + len / 2) / len;
		if (neg) begin
			if (q > 32768) q = 32768;
			return nrm_t'(16'd0 - q[15:0]);
		end
		if (q > 32767) q = 32767;
		return nrm_t'(q[15:0]);
	endfunction

	// Scale one accumulated sum to a unit normal
	function automatic normal_rec_t unit_normal(logic [VIDX_W-1:0] v, longint sx, longint sy,
			longint sz);
		normal_rec_t     r;
		longint unsigned mx, my, mz, m, len;
		int              s;
		r.vtx = v;
		if (sx == 0 && sy == 0 && sz == 0) begin
			r.nx = 0; r.ny = 0; r.nz = NRM_ONE; r.deg = 1'b1;
			return r;
		end
		mx = sx[63] ? ~sx + 1 : sx;
		my = sy[63] ? ~sy + 1 : sy;
		mz = sz[63] ? ~sz + 1 : sz;
		m = mx;
		if (my > m) m = my;
		if (mz > m) m = mz;
		s = 0;
		while ((m >> s) >= (64'd1 << 30)) s++;
		mx >>= s; my >>= s; mz >>= s;
		len = int_sqrt(mx * mx + my * my + mz * mz);
		if (len == 0) len = 1;
		r.nx = scale_part(mx, sx[63], len);
		r.ny = scale_part(my, sy[63], len);
		r.nz = scale_part(mz, sz[63], len);
		r.deg = 1'b0;
		return r;
	endfunction

	function automatic void add_area(int i, longint x, longint y, longint z);
		acc_x[i] = sat_sum(acc_x[i], x);
		acc_y[i] = sat_sum(acc_y[i], y);
		acc_z[i] = sat_sum(acc_z[i], z);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VERTS; i++) begin
				vpos_x[i] = 0; vpos_y[i] = 0; vpos_z[i] = 0;
				acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
			end
			vcount = 0;
			normals_due.delete();
			mism = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			// Compare each response beat with the oldest predicted normal
			if (rsp.valid && rsp.ready) begin
				got.vtx = rsp.queried_vertex;
				got.nx = rsp.normal_x;
				got.ny = rsp.normal_y;
				got.nz = rsp.normal_z;
				got.deg = rsp.degenerate;
				if (normals_due.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("unexpected normal beat: vertex %0d (%0d,%0d,%0d) deg %0b",
							got.vtx, got.nx, got.ny, got.nz, got.deg);
				end else begin
					want = normals_due.pop_front();
					if (got.vtx !== want.vtx || got.nx !== want.nx || got.ny !== want.ny ||
							got.nz !== want.nz || got.deg !== want.deg) begin
						mism++;
						if (mism <= 10)
							$display("normal mismatch: expected vertex %0d (%0d,%0d,%0d) deg %0b, got vertex %0d (%0d,%0d,%0d) deg %0b",
								want.vtx, want.nx, want.ny, want.nz, want.deg,
								got.vtx, got.nx, got.ny, got.nz, got.deg);
					end
				end
			end
			// Advance the shadow state by one request beat, using the old count
			if (req.valid && req.ready) begin
				case (opcode_t'(req.opcode))
					OP_LOAD: begin
						vpos_x[req.vertex_index] = req.pos_x;
						vpos_y[req.vertex_index] = req.pos_y;
						vpos_z[req.vertex_index] = req.pos_z;
						acc_x[req.vertex_index] = 0;
						acc_y[req.vertex_index] = 0;
						acc_z[req.vertex_index] = 0;
					end
					OP_TRI: begin
						ca = req.corner_a;
						cb = req.corner_b;
						cc = req.corner_c;
						lim = vcount < VERTS ? vcount : VERTS;
						if (ca >= 0 && cb >= 0 && cc >= 0 && ca < lim && cb < lim && cc < lim) begin
							e1x = vpos_x[cb] - vpos_x[ca];
							e1y = vpos_y[cb] - vpos_y[ca];
							e1z = vpos_z[cb] - vpos_z[ca];
							e2x = vpos_x[cc] - vpos_x[ca];
							e2y = vpos_y[cc] - vpos_y[ca];
							e2z = vpos_z[cc] - vpos_z[ca];
							cx = e1y * e2z - e1z * e2y;
							cy = e1z * e2x - e1x * e2z;
							cz = e1x * e2y - e1y * e2x;
							add_area(int'(ca), cx, cy, cz);
							add_area(int'(cb), cx, cy, cz);
							add_area(int'(cc), cx, cy, cz);
						end
					end
					OP_QUERY: begin
						normals_due.insert(normals_due.size(), unit_normal(req.vertex_index,
							acc_x[req.vertex_index], acc_y[req.vertex_index],
							acc_z[req.vertex_index]));
					end
					default: ;
				endcase
			end
			if (cfg.valid && cfg.ready)
				vcount = cfg.data;
			errors <= mism;
			pending <= normals_due.size();
		end
	end

endmodule

/* sim/vertex_normal_accumulator_unit_tb.sv */
module vertex_normal_accumulator_unit_tb;
	import vna_pkg::*;

	localparam int  VERTS = 4096;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int  RSP_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;
	longint cycles = 0;

	vna_req_if req_ch();
	vna_rsp_if rsp_ch();
	vna_cfg_if cfg_ch();

	vertex_normal_accumulator_unit #(.MAX_VERTICES(VERTS)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	normal_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.cfg     (cfg_ch),
		.errors  (errors),
		.pending (pending)
	);

	bit  loaded [VERTS];
	int  loaded_list[$];
	int  lim;
	bit  send_quiet;
	bit  recv_quiet;
	int  hold_asks;
	int  hold_seen;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bail out when the run hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("vertex_normal_accumulator_unit verification failed");
			$finish;
		end
	end

	// Response side: random stalls, quiet stretches and one long hold-off
	initial begin
		int stall;
		hold_seen = 0;
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD) @(posedge clk);
			end else begin
				stall = recv_quiet ? 0 : $urandom_range(0, 8);
				if (stall > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid && hold_asks == hold_seen) @(posedge clk);
		end
	end

	task automatic send_beat(input opcode_t op, input logic [VIDX_W-1:0] vi,
			input pos_t px, input pos_t py, input pos_t pz,
			input logic signed [CORNER_W-1:0] a, input logic signed [CORNER_W-1:0] b,
			input logic signed [CORNER_W-1:0] c);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.vertex_index <= vi;
		req_ch.pos_x <= px;
		req_ch.pos_y <= py;
		req_ch.pos_z <= pz;
		req_ch.corner_a <= a;
		req_ch.corner_b <= b;
		req_ch.corner_c <= c;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (op == OP_LOAD && !loaded[vi]) begin
			loaded[vi] = 1'b1;
			loaded_list.insert(loaded_list.size(), int'(vi));
		end
	endtask

	task automatic load_vertex(input int vi, input pos_t px, input pos_t py, input pos_t pz);
		send_beat(OP_LOAD, VIDX_W'(vi), px, py, pz, $urandom, $urandom, $urandom);
	endtask

	task automatic add_triangle(input logic signed [31:0] a, input logic signed [31:0] b,
			input logic signed [31:0] c);
		send_beat(OP_TRI, VIDX_W'($urandom), pos_t'($urandom), pos_t'($urandom),
			pos_t'($urandom), a, b, c);
	endtask

	task automatic query_vertex(input int vi);
		send_beat(OP_QUERY, VIDX_W'(vi), pos_t'($urandom), pos_t'($urandom), pos_t'($urandom),
			$urandom, $urandom, $urandom);
	endtask

	// Hold the input until every normal is back and the block has settled
	task automatic drain;
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_count(input int value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= CNT_W'(value);
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		lim = value < VERTS ? value : VERTS;
	endtask

	function automatic pos_t rand_pos();
		case ($urandom_range(0, 3))
			1: return pos_t'($signed($urandom_range(0, 2000)) - 1000);
			2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
			default: return pos_t'($urandom);
		endcase
	endfunction

	function automatic int rand_vertex();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 15) : $urandom_range(0, VERTS - 1);
	endfunction

	// Pick a loaded corner below the count, or -1 when none turns up
	function automatic int pick_corner();
		int v;
		if (loaded_list.size() == 0) return -1;
		for (int t = 0; t < 12; t++) begin
			v = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
			if (v < lim) return v;
		end
		return -1;
	endfunction

	task automatic random_triangle;
		logic signed [31:0] k[3];
		int bad;
		bit ok;
		ok = 1'b1;
		for (int i = 0; i < 3; i++) begin
			k[i] = pick_corner();
			if (k[i] < 0) ok = 1'b0;
		end
		// Break roughly a quarter of them, and any that found no usable corner
		if (!ok || $urandom_range(0, 3) == 0) begin
			bad = $urandom_range(0, 2);
			for (int i = 0; i < 3; i++)
				if (k[i] < 0 || $urandom_range(0, 2) == 0) k[i] = $urandom;
			if ($urandom_range(0, 1))
				k[bad] = $urandom | 32'h8000_0000;
			else
				k[bad] = lim + $urandom_range(0, 32'h7fff_0000);
		end
		add_triangle(k[0], k[1], k[2]);
	endtask

	task automatic random_items(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				load_vertex(rand_vertex(), rand_pos(), rand_pos(), rand_pos());
			else if (r < 70)
				random_triangle();
			else if (r < 95)
				query_vertex(rand_vertex());
			else
				send_beat(OP_NOP, VIDX_W'($urandom), pos_t'($urandom), pos_t'($urandom),
					pos_t'($urandom), $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		int counts[8];
		hold_asks = 0;
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
		lim = 0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_NOP;
		req_ch.vertex_index = '0;
		req_ch.pos_x = '0;
		req_ch.pos_y = '0;
		req_ch.pos_z = '0;
		req_ch.corner_a = '0;
		req_ch.corner_b = '0;
		req_ch.corner_c = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme positions, rejected corners, zero sums
		write_count(16);
		load_vertex(0, 24'sh800000, 24'sh800000, 24'sh800000);
		load_vertex(1, 24'sh7fffff, 24'sh800000, 24'sh800000);
		load_vertex(2, 24'sh800000, 24'sh7fffff, 24'sh800000);
		load_vertex(3, 24'sh000000, 24'sh000000, 24'sh7fffff);
		add_triangle(0, 1, 2);
		add_triangle(0, 1, 3);
		add_triangle(2, 1, 3);
		add_triangle(-1, 0, 1);
		add_triangle(0, 16, 1);
		add_triangle(32'sh7fffffff, 1, 2);
		add_triangle(0, 1, 32'sh80000000);
		load_vertex(5, 24'sh123456, 24'shfedcba, 24'sh000001);
		add_triangle(5, 5, 5);
		query_vertex(0);
		query_vertex(1);
		query_vertex(2);
		query_vertex(3);
		query_vertex(5);
		query_vertex(4095);
		send_beat(OP_NOP, 12'hfff, 24'shffffff, 24'shffffff, 24'shffffff, -1, -1, -1);
		load_vertex(4095, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
		query_vertex(4095);
		load_vertex(0, 24'sh000000, 24'sh000000, 24'sh000000);
		query_vertex(0);
		drain();

		counts = '{0, 1, 3, 4096, 8191, 4, 16, 0};
		counts[7] = $urandom_range(0, 8191);
		for (int p = 0; p < 8; p++) begin
			write_count(counts[p]);
			send_quiet = (p == 2);
			recv_quiet = (p == 5);
			if (p == 3) begin
				// Fill the block behind a stalled response side
				hold_asks++;
				send_quiet = 1'b1;
				for (int i = 0; i < 20; i++) query_vertex(rand_vertex());
				send_quiet = 1'b0;
			end
			random_items(215);
			drain();
		end

		if (errors == 0)
			$display("vertex_normal_accumulator_unit verification clean");
		else
			$display("vertex_normal_accumulator_unit verification failed");
		$finish;
	end

endmodule
